@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define SPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is low.
`define SPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/spl_pkg.sv @@
`default_nettype none

package spl_pkg;

	// Q1.24 gain format
	localparam int GAIN_W = 25;
	localparam int FRAC_W = 24;

	typedef logic [GAIN_W-1:0] gain_t;

	localparam gain_t Q_ONE = 25'h100_0000;

	// Register reset values
	localparam logic [31:0] THRESH_RST = 32'd7549747;
	localparam gain_t COEF_RST = 25'd6987;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_RELEASE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PEAK,
		ST_LIMIT,
		ST_DIV,
		ST_GAIN,
		ST_REL,
		ST_APPLY,
		ST_SCALE
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/spl_in_if.sv @@
`default_nettype none

interface spl_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spl_out_if.sv @@
`default_nettype none

interface spl_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	spl_pkg::gain_t gain_out;

	modport source (output valid, output left_out, output right_out, output gain_out,
		input ready);
	modport sink (input valid, input left_out, input right_out, input gain_out,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/spl_cfg_if.sv @@
`default_nettype none

interface spl_cfg_if #(
	parameter int DATA_W = 25
);
	logic valid;
	logic ready;
	spl_pkg::cfg_idx_t index;
	logic [DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spl_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// quo = floor(num * 2^FRAC_W / den), needs num < den.
module spl_div #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-2:0] num,
	input  wire logic [SAMPLE_BITS-1:0] den,
	output logic                        busy,
	output logic [spl_pkg::FRAC_W-1:0]  quo
);

	localparam int CNT_W = $clog2(spl_pkg::FRAC_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(spl_pkg::FRAC_W - 1);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [SAMPLE_BITS-2:0]      rem_q;
	logic [SAMPLE_BITS-1:0]      den_q;
	logic [spl_pkg::FRAC_W-1:0]  quo_q;

	logic [SAMPLE_BITS-1:0]      shifted;
	logic [SAMPLE_BITS:0]        diff;
	logic                        ge;

	// rem < den <= 2^(S-1), so the doubled remainder fits in S bits
	assign shifted = {rem_q, 1'b0};
	assign diff    = {1'b0, shifted} - {1'b0, den_q};
	assign ge      = ~diff[SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SAMPLE_BITS-2:0] : shifted[SAMPLE_BITS-2:0];
			quo_q <= {quo_q[spl_pkg::FRAC_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/spl_smul.sv @@
`default_nettype none

// Serial shift-add multiplier, multiplier bits LSB first, one per cycle.
// prod = (a * b + 2^23) >> 24, with b <= unity so prod <= a.
module spl_smul #(
	parameter int W = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   a,
	input  wire spl_pkg::gain_t b,
	output logic                busy,
	output logic [W-1:0]        prod
);

	localparam int GW = spl_pkg::GAIN_W;
	localparam int CNT_W = $clog2(GW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GW - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     acc_q;
	logic [W-1:0]     a_q;
	logic [GW-1:0]    mul_q;
	logic [GW-1:0]    low_q;

	logic [W:0]       sum;
	logic [W:0]       rnd;

	assign sum = {1'b0, acc_q} + (mul_q[0] ? {1'b0, a_q} : '0);

	// low_q holds product bits 24..0; round on bit 23
	assign rnd = {acc_q, low_q[GW-1]} + {{W{1'b0}}, low_q[GW-2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			mul_q <= b;
			low_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum[W:1];
			low_q <= {sum[0], low_q[GW-1:1]};
			mul_q <= {1'b0, mul_q[GW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = rnd[W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/stereo_peak_limiter_unit.sv @@
//  channel  | kind        | carries
//  ---------+-------------+------------------------------------------------
//  smp      | sink        | left_in, right_in: signed stereo sample pair
//  res      | source      | left_out, right_out, gain_out (Q1.24)
//  cfg      | sink        | index 0 threshold, index 1 release_coef
//
//  One pair at a time: the next beat is accepted only once the result of the
//  last one is loaded. The divide (24 quotient bits) runs only when the peak
//  exceeds the threshold, the release multiply (25 bits) only when the gain
//  rises toward its target; the serial scaling multipliers run for every pair.
//  Reset: gain to unity, registers to their reset values, result empty.
//  A waiting result sits in the output register; a stalled res only holds
//  the block in the final scaling state until the register frees up.
`default_nettype none

`include "assert_macros.svh"

module stereo_peak_limiter_unit #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spl_in_if.sink    smp,
	spl_out_if.source res,
	spl_cfg_if.sink   cfg
);

	localparam int S  = SAMPLE_BITS;
	localparam int GW = spl_pkg::GAIN_W;

	// config registers
	logic [S-2:0]       thr_q;
	spl_pkg::gain_t     coef_q;
	spl_pkg::gain_t     coef_sat;

	// control
	spl_pkg::state_t    state_q, state_d;
	logic               res_valid_q;

	// per-item datapath
	logic [S-1:0]       lmag_q, rmag_q, peak_q;
	logic               lneg_q, rneg_q;
	spl_pkg::gain_t     target_q;
	spl_pkg::gain_t     gain_q;
	logic [S-1:0]       lmag_c, rmag_c, lraw, rraw;
	logic               peak_gt;
	logic [GW:0]        gdiff;
	logic               attack, gap_zero;

	// unit handshakes
	logic               div_start, rel_start, sc_start, load_out;
	logic               div_busy, rel_busy, lsc_busy, rsc_busy;
	logic [spl_pkg::FRAC_W-1:0] quo;
	spl_pkg::gain_t     rel_step;
	logic [S-1:0]       lprod, rprod;

	// result register
	logic signed [S-1:0] left_out_q, right_out_q;
	spl_pkg::gain_t      gain_out_q;

	// ---------------------------------------------------------------
	// Configuration: always ready, unknown indexes are dropped
	// ---------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= spl_pkg::THRESH_RST[S-2:0];
			coef_q <= spl_pkg::COEF_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				spl_pkg::CFG_THRESHOLD: thr_q  <= cfg.data[S-2:0];
				spl_pkg::CFG_RELEASE:   coef_q <= cfg.data[GW-1:0];
				default: ;
			endcase
		end
	end

	// coef above unity has bit 24 set; clamp to unity
	assign coef_sat = coef_q[GW-1] ? spl_pkg::Q_ONE : coef_q;

	// ---------------------------------------------------------------
	// Front end: sign/magnitude split at accept, peak next cycle
	// ---------------------------------------------------------------
	assign lraw   = smp.left_in;
	assign rraw   = smp.right_in;
	// most negative value maps to 2^(S-1), still exact in S unsigned bits
	assign lmag_c = lraw[S-1] ? (~lraw + {{(S-1){1'b0}}, 1'b1}) : lraw;
	assign rmag_c = rraw[S-1] ? (~rraw + {{(S-1){1'b0}}, 1'b1}) : rraw;

	assign peak_gt = peak_q > {1'b0, thr_q};

	// one subtract gives both the gap and the attack decision
	assign gdiff    = {1'b0, target_q} - {1'b0, gain_q};
	assign attack   = gdiff[GW];
	assign gap_zero = (gdiff == '0);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			spl_pkg::ST_IDLE:  if (smp.valid) state_d = spl_pkg::ST_PEAK;
			spl_pkg::ST_PEAK:  state_d = spl_pkg::ST_LIMIT;
			spl_pkg::ST_LIMIT: state_d = peak_gt ? spl_pkg::ST_DIV : spl_pkg::ST_GAIN;
			spl_pkg::ST_DIV:   if (!div_busy) state_d = spl_pkg::ST_GAIN;
			spl_pkg::ST_GAIN: begin
				if (attack || gap_zero) begin
					state_d = spl_pkg::ST_APPLY;
				end else begin
					state_d = spl_pkg::ST_REL;
				end
			end
			spl_pkg::ST_REL:   if (!rel_busy) state_d = spl_pkg::ST_APPLY;
			spl_pkg::ST_APPLY: state_d = spl_pkg::ST_SCALE;
			spl_pkg::ST_SCALE: if (load_out) state_d = spl_pkg::ST_IDLE;
			default:           state_d = spl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		smp.ready = (state_q == spl_pkg::ST_IDLE);
		div_start = (state_q == spl_pkg::ST_LIMIT) && peak_gt;
		rel_start = (state_q == spl_pkg::ST_GAIN) && !attack && !gap_zero;
		sc_start  = (state_q == spl_pkg::ST_APPLY);
		load_out  = (state_q == spl_pkg::ST_SCALE) && !lsc_busy &&
			(!res_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Kept gain: the only datapath state carried on from one item to the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= spl_pkg::Q_ONE;
		end else if (state_q == spl_pkg::ST_GAIN && attack) begin
			gain_q <= target_q;
		end else if (state_q == spl_pkg::ST_REL && !rel_busy) begin
			gain_q <= gain_q + rel_step;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			lmag_q <= lmag_c;
			rmag_q <= rmag_c;
			lneg_q <= lraw[S-1];
			rneg_q <= rraw[S-1];
		end
		if (state_q == spl_pkg::ST_PEAK) begin
			peak_q <= (lmag_q > rmag_q) ? lmag_q : rmag_q;
		end
		if (state_q == spl_pkg::ST_LIMIT && !peak_gt) begin
			target_q <= spl_pkg::Q_ONE;
		end else if (state_q == spl_pkg::ST_DIV && !div_busy) begin
			target_q <= {1'b0, quo};
		end
	end

	// ---------------------------------------------------------------
	// Serial units
	// ---------------------------------------------------------------
	spl_div #(
		.SAMPLE_BITS(S)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (thr_q),
		.den    (peak_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	spl_smul #(
		.W(GW)
	) u_rel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rel_start),
		.a      (gdiff[GW-1:0]),
		.b      (coef_sat),
		.busy   (rel_busy),
		.prod   (rel_step)
	);

	spl_smul #(
		.W(S)
	) u_lsc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.a      (lmag_q),
		.b      (gain_q),
		.busy   (lsc_busy),
		.prod   (lprod)
	);

	spl_smul #(
		.W(S)
	) u_rsc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.a      (rmag_q),
		.b      (gain_q),
		.busy   (rsc_busy),
		.prod   (rprod)
	);

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// magnitude never grows, so putting the sign back cannot overflow
	always_ff @(posedge clk) begin
		if (load_out) begin
			left_out_q  <= lneg_q ? (~lprod + {{(S-1){1'b0}}, 1'b1}) : lprod;
			right_out_q <= rneg_q ? (~rprod + {{(S-1){1'b0}}, 1'b1}) : rprod;
			gain_out_q  <= gain_q;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.left_out  = left_out_q;
	assign res.right_out = right_out_q;
	assign res.gain_out  = gain_out_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`SPL_ASSERT_IMP(a_gain_le_unity, clk, arst_n, 1'b1, gain_q <= spl_pkg::Q_ONE)
	`SPL_ASSERT_IMP(a_scalers_lockstep, clk, arst_n, 1'b1, lsc_busy == rsc_busy)
	`SPL_ASSERT_NXT(a_accept_to_peak, clk, arst_n, smp.valid && smp.ready, state_q == spl_pkg::ST_PEAK)
	`SPL_ASSERT_IMP(a_div_only_limiting, clk, arst_n, div_start, peak_q > {1'b0, thr_q})

endmodule

`default_nettype wire
